FILE: hw/rtl/yuvds_pkg.sv
// Shared constants, types and helpers for the YUV420 nearest-neighbour downscaler.
`default_nettype none

package yuvds_pkg;

    // Frame limits and fixed-point format
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int FRAC_BITS  = 16;

    // Field widths fixed by the register map and the pixel format
    localparam int DIM_W  = 13;
    localparam int STEP_W = 29;
    localparam int PIX_W  = 8;
    localparam int DATA_W = 29;
    localparam int IDX_W  = 3;

    // Derived widths
    localparam int SCOL_W = $clog2(MAX_WIDTH);
    localparam int SROW_W = $clog2(MAX_HEIGHT);
    localparam int WSZ_W  = SCOL_W + 1;
    localparam int HSZ_W  = SROW_W + 1;
    localparam int PICK_W = STEP_W + 1 - FRAC_BITS;
    localparam int CMPC_W = (SCOL_W > PICK_W) ? SCOL_W : PICK_W;
    localparam int CMPR_W = (SROW_W > PICK_W) ? SROW_W : PICK_W;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [STEP_W-1:0] t_pos;
    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [SCOL_W-1:0] t_scol;
    typedef logic [SROW_W-1:0] t_srow;
    typedef logic [WSZ_W-1:0]  t_wsz;
    typedef logic [HSZ_W-1:0]  t_hsz;
    typedef logic [PICK_W-1:0] t_pick;
    typedef logic [CMPC_W-1:0] t_cmpc;
    typedef logic [CMPR_W-1:0] t_cmpr;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_H_STEP     = 3'd4,
        CFG_V_STEP     = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam t_dim RST_SRC_WIDTH  = t_dim'(1280);
    localparam t_dim RST_SRC_HEIGHT = t_dim'(720);
    localparam t_dim RST_DST_WIDTH  = t_dim'(320);
    localparam t_dim RST_DST_HEIGHT = t_dim'(180);
    localparam t_pos RST_STEP       = t_pos'(4) << FRAC_BITS;

    localparam t_pos ONE_Q   = t_pos'(1) << FRAC_BITS;
    localparam t_pos HALF_Q  = t_pos'(1) << (FRAC_BITS - 1);
    localparam t_pos POS_MAX = '1;

    // Source position picked by a Q position: round to nearest
    function automatic t_pick pick(input t_pos p);
        logic [STEP_W:0] sum;
        sum = {1'b0, p} + {1'b0, HALF_Q};
        return sum[STEP_W:FRAC_BITS];
    endfunction

    // Advance a position by a step of at least one, saturating
    function automatic t_pos pos_add(input t_pos p, input t_pos s);
        t_pos            s_eff;
        logic [STEP_W:0] sum;
        s_eff = (s < ONE_Q) ? ONE_Q : s;
        sum   = {1'b0, p} + {1'b0, s_eff};
        return sum[STEP_W] ? POS_MAX : sum[STEP_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/yuv420_nearest_downscale.sv
// Top level of the YUV420 nearest-neighbour downscaler.
//
// Source pixels enter in raster order on i_valid / o_ready, each with its
// luma and the U and V of its 2x2 chroma block. One transfer is taken in
// every cycle while the output register is empty or being emptied.
// A source pixel that lands on a destination pick is registered and leaves
// on o_valid / i_ready with line and frame end flags; chroma
// is passed only on even destination columns of even destination rows.
// Other source pixels only advance the counters and give no result.
// Throughput is one pixel per cycle while the receiver does not stall, with
// a single result register after the counter and position adders.
// When the receiver stalls, the pending result holds and o_ready drops, so
// the source stalls too; input transfers resume in the cycle it is taken.
// Reset (synchronous, active low) clears all counters and positions, empties
// the result register and loads the register defaults: 1280x720 source,
// 320x180 destination, steps of 4.0. The user must write registers through
// the plain write port only while the stream is idle; this is not enforced.
`default_nettype none

module yuv420_nearest_downscale
    import yuvds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_wr_en,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_wdata,
    // source pixels
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [PIX_W-1:0]  i_luma,
    input  wire logic [PIX_W-1:0]  i_chroma_u,
    input  wire logic [PIX_W-1:0]  i_chroma_v,
    // destination pixels
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [PIX_W-1:0]       o_luma_out,
    output logic [PIX_W-1:0]       o_u_out,
    output logic [PIX_W-1:0]       o_v_out,
    output logic                   o_chroma_valid,
    output logic                   o_line_end,
    output logic                   o_frame_end
);

    // Configuration registers
    t_dim r_src_width, r_src_height, r_dst_width, r_dst_height;
    t_pos r_h_step, r_v_step;

    // Scan state
    t_scol r_src_col, n_src_col;
    t_srow r_src_row, n_src_row;
    t_dim  r_dst_col, n_dst_col;
    t_dim  r_dst_row, n_dst_row;
    t_pos  r_col_pos, n_col_pos;
    t_pos  r_row_pos, n_row_pos;

    // Result register
    logic  r_valid, n_valid;
    t_pix  r_luma, r_u, r_v;
    logic  r_cv, r_le, r_fe;

    logic  accept;
    t_wsz  w_eff;
    t_hsz  h_eff;
    logic  row_hit, col_hit, last_col, last_row;
    logic  cv, le, fe;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Clamp the source size to one .. maximum
    always_comb begin
        if (r_src_width == '0) begin
            w_eff = t_wsz'(1);
        end else if ({1'b0, r_src_width} > (DIM_W+1)'(MAX_WIDTH)) begin
            w_eff = t_wsz'(MAX_WIDTH);
        end else begin
            w_eff = t_wsz'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_eff = t_hsz'(1);
        end else if ({1'b0, r_src_height} > (DIM_W+1)'(MAX_HEIGHT)) begin
            h_eff = t_hsz'(MAX_HEIGHT);
        end else begin
            h_eff = t_hsz'(r_src_height);
        end
    end

    // Pick test and flags for the current source pixel
    always_comb begin
        row_hit  = (t_cmpr'(r_src_row) == t_cmpr'(pick(r_row_pos)))
                   && (r_dst_row < r_dst_height);
        col_hit  = row_hit && (r_dst_col < r_dst_width)
                   && (t_cmpc'(r_src_col) == t_cmpc'(pick(r_col_pos)));
        cv       = !r_dst_col[0] && !r_dst_row[0];
        le       = ({1'b0, r_dst_col} + 1'b1) == {1'b0, r_dst_width};
        fe       = le && (({1'b0, r_dst_row} + 1'b1) == {1'b0, r_dst_height});
        last_col = ({1'b0, r_src_col} + 1'b1) >= w_eff;
        last_row = ({1'b0, r_src_row} + 1'b1) >= h_eff;
    end

    // Next scan state: column first, then the row at a line end
    always_comb begin
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        n_dst_col = r_dst_col;
        n_dst_row = r_dst_row;
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        if (col_hit) begin
            n_dst_col = r_dst_col + 1'b1;
            n_col_pos = pos_add(r_col_pos, r_h_step);
        end
        if (last_col) begin
            n_src_col = '0;
            n_dst_col = '0;
            n_col_pos = '0;
            if (last_row) begin
                n_src_row = '0;
                n_dst_row = '0;
                n_row_pos = '0;
            end else begin
                if (row_hit) begin
                    n_dst_row = r_dst_row + 1'b1;
                    n_row_pos = pos_add(r_row_pos, r_v_step);
                end
                n_src_row = r_src_row + 1'b1;
            end
        end else begin
            n_src_col = r_src_col + 1'b1;
        end
    end

    // Result valid: load on a transfer in, drop once taken
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = col_hit;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
            r_h_step     <= RST_STEP;
            r_v_step     <= RST_STEP;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_dst_col    <= '0;
            r_dst_row    <= '0;
            r_col_pos    <= '0;
            r_row_pos    <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata[DIM_W-1:0];
                    CFG_SRC_HEIGHT: r_src_height <= i_cfg_wdata[DIM_W-1:0];
                    CFG_DST_WIDTH:  r_dst_width  <= i_cfg_wdata[DIM_W-1:0];
                    CFG_DST_HEIGHT: r_dst_height <= i_cfg_wdata[DIM_W-1:0];
                    CFG_H_STEP:     r_h_step     <= i_cfg_wdata[STEP_W-1:0];
                    CFG_V_STEP:     r_v_step     <= i_cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
                r_dst_col <= n_dst_col;
                r_dst_row <= n_dst_row;
                r_col_pos <= n_col_pos;
                r_row_pos <= n_row_pos;
            end
            r_valid <= n_valid;
        end
    end

    // Result payload: load on a transfer that hits a pick
    always_ff @(posedge i_clk) begin
        if (accept && col_hit) begin
            r_luma <= i_luma;
            r_u    <= cv ? i_chroma_u : '0;
            r_v    <= cv ? i_chroma_v : '0;
            r_cv   <= cv;
            r_le   <= le;
            r_fe   <= fe;
        end
    end

    assign o_valid        = r_valid;
    assign o_luma_out     = r_luma;
    assign o_u_out        = r_u;
    assign o_v_out        = r_v;
    assign o_chroma_valid = r_cv;
    assign o_line_end     = r_le;
    assign o_frame_end    = r_fe;

endmodule

`default_nettype wire

FILE: hw/rtl/yuvds_checker.sv
// Port-level checks on the downscaler, bound to its top level.
`default_nettype none

module yuvds_checker
    import yuvds_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [PIX_W-1:0] o_u_out,
    input wire logic [PIX_W-1:0] o_v_out,
    input wire logic             o_chroma_valid,
    input wire logic             o_line_end,
    input wire logic             o_frame_end
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // Input stalls only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a stalled result");

    // A stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("stalled result dropped");

    // Frame end only on a line end
    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_line_end)
        else $error("frame end without line end");

    // Chroma is zero where it is not carried
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_chroma_valid) |-> (o_u_out == '0 && o_v_out == '0))
        else $error("chroma not cleared on an odd position");

endmodule

bind yuv420_nearest_downscale yuvds_checker u_yuvds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_u_out        (o_u_out),
    .o_v_out        (o_v_out),
    .o_chroma_valid (o_chroma_valid),
    .o_line_end     (o_line_end),
    .o_frame_end    (o_frame_end)
);

`default_nettype wire

FILE: dv/yuv420_nearest_downscale_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the YUV420 nearest-neighbour downscaler.
module yuv420_nearest_downscale_tb;
    import yuvds_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RANDOM_ITEMS   = 700;
    localparam int unsigned Q_ONE          = 32'd1 << FRAC_BITS;

    typedef struct packed {
        t_pix luma;
        t_pix u;
        t_pix v;
        logic chroma_valid;
        logic line_end;
        logic frame_end;
    } t_dest_pixel;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_wdata = '0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    t_pix              i_luma      = '0;
    t_pix              i_chroma_u  = '0;
    t_pix              i_chroma_v  = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    t_pix              o_luma_out;
    t_pix              o_u_out;
    t_pix              o_v_out;
    logic              o_chroma_valid;
    logic              o_line_end;
    logic              o_frame_end;

    // Register shadow, reset defaults
    t_dim cfg_src_w  = RST_SRC_WIDTH;
    t_dim cfg_src_h  = RST_SRC_HEIGHT;
    t_dim cfg_dst_w  = RST_DST_WIDTH;
    t_dim cfg_dst_h  = RST_DST_HEIGHT;
    t_pos cfg_h_step = RST_STEP;
    t_pos cfg_v_step = RST_STEP;

    // Scan counters and Q positions of the predictor
    t_scol src_col = '0;
    t_srow src_row = '0;
    t_dim  dst_col = '0;
    t_dim  dst_row = '0;
    t_pos  col_pos = '0;
    t_pos  row_pos = '0;

    t_dest_pixel expected_dest_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct   = 20;
    int unsigned snk_idle_pct   = 20;
    int unsigned ready_hold     = 0;

    yuv420_nearest_downscale u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_luma         (i_luma),
        .i_chroma_u     (i_chroma_u),
        .i_chroma_v     (i_chroma_v),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_luma_out     (o_luma_out),
        .o_u_out        (o_u_out),
        .o_v_out        (o_v_out),
        .o_chroma_valid (o_chroma_valid),
        .o_line_end     (o_line_end),
        .o_frame_end    (o_frame_end)
    );

    always #10 i_clk = ~i_clk;

    // Zero acts as one, oversize acts as the frame limit
    function automatic int unsigned eff_size(input t_dim sz, input int unsigned limit);
        if (sz == '0) begin
            return 1;
        end
        return (32'(sz) > limit) ? limit : 32'(sz);
    endfunction

    // Source index a Q position rounds to
    function automatic int unsigned nearest_src(input t_pos p);
        return (32'(p) + (Q_ONE >> 1)) >> FRAC_BITS;
    endfunction

    // Step a Q position, step floored at one, sum saturating
    function automatic t_pos advance_pos(input t_pos p, input t_pos s);
        int unsigned s_q;
        int unsigned sum;
        s_q = (32'(s) < Q_ONE) ? Q_ONE : 32'(s);
        sum = 32'(p) + s_q;
        return (sum > ((32'd1 << STEP_W) - 1)) ? '1 : t_pos'(sum);
    endfunction

    // Predict the destination pixel, if any, of one source pixel
    task automatic scale_pixel(input t_pix y_in, input t_pix u_in, input t_pix v_in);
        int unsigned w;
        int unsigned h;
        logic        row_hit;
        t_dest_pixel px;
        w = eff_size(cfg_src_w, MAX_WIDTH);
        h = eff_size(cfg_src_h, MAX_HEIGHT);
        row_hit = (32'(src_row) == nearest_src(row_pos)) && (dst_row < cfg_dst_h);
        if (row_hit && dst_col < cfg_dst_w && 32'(src_col) == nearest_src(col_pos)) begin
            px.chroma_valid = !dst_col[0] && !dst_row[0];
            px.line_end     = (32'(dst_col) + 1 == 32'(cfg_dst_w));
            px.frame_end    = px.line_end && (32'(dst_row) + 1 == 32'(cfg_dst_h));
            px.luma         = y_in;
            px.u            = px.chroma_valid ? u_in : '0;
            px.v            = px.chroma_valid ? v_in : '0;
            expected_dest_pixels.push_back(px);
            dst_col = dst_col + 1'b1;
            col_pos = advance_pos(col_pos, cfg_h_step);
        end
        // Wrap at the last column, then at the last row
        if (32'(src_col) + 1 >= w) begin
            src_col = '0;
            dst_col = '0;
            col_pos = '0;
            if (32'(src_row) + 1 >= h) begin
                src_row = '0;
                dst_row = '0;
                row_pos = '0;
            end else begin
                if (row_hit) begin
                    dst_row = dst_row + 1'b1;
                    row_pos = advance_pos(row_pos, cfg_v_step);
                end
                src_row = src_row + 1'b1;
            end
        end else begin
            src_col = src_col + 1'b1;
        end
    endtask

    // Send one source pixel and hold it until the transfer
    task automatic send_pixel(input t_pix y_in, input t_pix u_in, input t_pix v_in);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 15);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_luma     <= y_in;
        i_chroma_u <= u_in;
        i_chroma_v <= v_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scale_pixel(y_in, u_in, v_in);
    endtask

    task automatic stream_pixels(input int unsigned count);
        repeat (count) send_pixel(t_pix'($urandom), t_pix'($urandom), t_pix'($urandom));
    endtask

    // Drop valid and wait until every destination pixel has left
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (expected_dest_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Write all six registers while the stream is idle
    task automatic load_config(input int unsigned sw, input int unsigned sh,
                               input int unsigned dw, input int unsigned dh,
                               input int unsigned hs, input int unsigned vs);
        drain_pipeline();
        put_reg(CFG_SRC_WIDTH, DATA_W'(sw));
        put_reg(CFG_SRC_HEIGHT, DATA_W'(sh));
        put_reg(CFG_DST_WIDTH, DATA_W'(dw));
        put_reg(CFG_DST_HEIGHT, DATA_W'(dh));
        put_reg(CFG_H_STEP, DATA_W'(hs));
        put_reg(CFG_V_STEP, DATA_W'(vs));
        i_cfg_wr_en <= 1'b0;
        cfg_src_w  = t_dim'(sw);
        cfg_src_h  = t_dim'(sh);
        cfg_dst_w  = t_dim'(dw);
        cfg_dst_h  = t_dim'(dh);
        cfg_h_step = t_pos'(hs);
        cfg_v_step = t_pos'(vs);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each destination transfer with the oldest prediction
    always @(posedge i_clk) begin : check_dest
        t_dest_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_dest_pixels.size() == 0) begin
                $error("luma_out: expected no pixel, got %0d", o_luma_out);
                mismatch_count++;
            end else begin
                want = expected_dest_pixels.pop_front();
                check_field("luma_out", 32'(want.luma), 32'(o_luma_out));
                check_field("u_out", 32'(want.u), 32'(o_u_out));
                check_field("v_out", 32'(want.v), 32'(o_v_out));
                check_field("chroma_valid", 32'(want.chroma_valid), 32'(o_chroma_valid));
                check_field("line_end", 32'(want.line_end), 32'(o_line_end));
                check_field("frame_end", 32'(want.frame_end), 32'(o_frame_end));
            end
        end
    end

    // Stall the receiver in bursts
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < snk_idle_pct) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 14);
        end else begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 19);
        end
    end

    // End the run when no transfer happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Default 1280x720 to 320x180 at step 4.0, no writes
    task automatic test_reset_values();
        stream_pixels(5);
    endtask

    // Zero width acts as one, steps below one act as one
    task automatic test_zero_size_slow_step();
        load_config(0, 3, 1, 3, 32'h0000_8000, 0);
        stream_pixels(3);
    endtask

    // Every source pixel picked, sample extremes
    task automatic test_tiny_frame();
        load_config(2, 2, 2, 2, Q_ONE, Q_ONE);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
    endtask

    // Largest steps saturate the position; targets beyond the line never match
    task automatic test_position_saturation();
        load_config(4, 1, 3, 1, '1, '1);
        stream_pixels(4);
    endtask

    task automatic test_empty_destination();
        load_config(3, 1, 0, 0, Q_ONE, Q_ONE);
        stream_pixels(3);
    endtask

    // Oversize width acts as the frame limit, not as its low twelve bits
    task automatic test_widest_line();
        src_idle_pct = 5;
        snk_idle_pct = 5;
        load_config(MAX_WIDTH + 8, 8191, 4, 8191, 16 << FRAC_BITS, Q_ONE);
        stream_pixels(64);
    endtask

    // Shrink the source width with the column counter beyond the new end
    task automatic test_resize_mid_frame();
        src_idle_pct = 20;
        snk_idle_pct = 20;
        load_config(8, 4, 4, 2, 2 << FRAC_BITS, 2 << FRAC_BITS);
        stream_pixels(5);
        load_config(3, 4, 4, 2, 2 << FRAC_BITS, 2 << FRAC_BITS);
        stream_pixels(3);
    endtask

    task automatic pick_idle_mix();
        case ($urandom_range(0, 2))
            0: src_idle_pct = 0;
            1: src_idle_pct = 15;
            default: src_idle_pct = 50;
        endcase
        case ($urandom_range(0, 2))
            0: snk_idle_pct = 0;
            1: snk_idle_pct = 15;
            default: snk_idle_pct = 50;
        endcase
    endtask

    // Small random frames, mostly nominal steps, some whole and some cut short
    task automatic test_random_frames(input int unsigned item_goal);
        int unsigned       sent;
        int unsigned       sw;
        int unsigned       sh;
        int unsigned       dw;
        int unsigned       dh;
        int unsigned       hs;
        int unsigned       vs;
        int unsigned       count;
        logic [DATA_W-1:0] sw_w;
        logic [DATA_W-1:0] dh_w;
        sent = 0;
        while (sent < item_goal) begin
            sw = $urandom_range(2, 24);
            sh = $urandom_range(2, 10);
            dw = $urandom_range(1, sw);
            dh = $urandom_range(1, sh);
            case ($urandom_range(0, 9))
                0: dw = 0;
                1: dh = 0;
                2: dw = $urandom_range(sw + 1, sw + 3);
                3: dh = $urandom_range(sh + 1, sh + 3);
                default: ;
            endcase
            hs = (sw << FRAC_BITS) / ((dw == 0) ? 1 : dw);
            vs = (sh << FRAC_BITS) / ((dh == 0) ? 1 : dh);
            case ($urandom_range(0, 7))
                0: hs = $urandom_range(0, 6 << FRAC_BITS);
                1: vs = $urandom_range(0, 6 << FRAC_BITS);
                2: hs = $urandom_range(Q_ONE, (32'd1 << STEP_W) - 1);
                3: vs = $urandom_range(Q_ONE, (32'd1 << STEP_W) - 1);
                default: ;
            endcase
            // Unused high bits of the size registers are ignored
            sw_w = DATA_W'(sw);
            dh_w = DATA_W'(dh);
            if ($urandom_range(0, 7) == 0) begin
                sw_w[DATA_W-1:DIM_W] = (DATA_W-DIM_W)'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                dh_w[DATA_W-1:DIM_W] = (DATA_W-DIM_W)'($urandom);
            end
            pick_idle_mix();
            load_config(32'(sw_w), sh, dw, 32'(dh_w), hs, vs);
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, sw * sh - 1);
            end else begin
                count = sw * sh * $urandom_range(1, 2);
            end
            stream_pixels(count);
            sent += count;
        end
    endtask

    // Back-to-back transfers on both sides
    task automatic test_full_rate_tail();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_config(16, 6, 5, 3, (16 << FRAC_BITS) / 5, 2 << FRAC_BITS);
        stream_pixels(16 * 6 * 2);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_zero_size_slow_step();
        test_tiny_frame();
        test_position_saturation();
        test_empty_destination();
        test_widest_line();
        test_resize_mid_frame();
        test_random_frames(RANDOM_ITEMS);
        test_full_rate_tail();
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
